/* hdl/record_list_shift_insert_argmin_assert.svh */
// Assertion macros used by the checker file of the record list block.
// Expects signals named clk and arst_n in the scope of use.
`ifndef RECORD_LIST_SHIFT_INSERT_ARGMIN_ASSERT_SVH
`define RECORD_LIST_SHIFT_INSERT_ARGMIN_ASSERT_SVH

// same-cycle implication
`define RLSIA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlsia: same-cycle check failed");

// next-cycle implication
`define RLSIA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlsia: next-cycle check failed");

`endif

/* hdl/rlsia_pkg.sv */
// Shared types and constants for the record list block.
// No dependencies; imported by every module of the block except rlsia_ram.
`timescale 1ns / 1ps

package rlsia_pkg;

	localparam int LIST_DEPTH = 128;
	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int LEN_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_SWAP   = 2'd2,
		FUNC_FIND   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] item_code;
		logic signed [31:0] item_price;
		logic signed [31:0] item_quantity;
		logic [7:0]         remove_count;
		logic [7:0]         pos_first;
		logic [7:0]         pos_second;
	} req_beat_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         list_length;
		logic [6:0]         found_index;
		logic signed [31:0] found_code;
		logic signed [31:0] found_price;
		logic signed [31:0] found_quantity;
	} rsp_beat_t;

	typedef struct packed {
		logic signed [31:0] code;
		logic signed [31:0] price;
		logic signed [31:0] quantity;
	} record_t;

	localparam int REC_W = $bits(record_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SW_RD2,
		S_SW_WR1,
		S_SW_WR2,
		S_FD_RUN,
		S_FD_TAIL,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_SECOND,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_INSERT,
		WR_FIRST,
		WR_SECOND
	} wr_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    set_status;
		status_t status;
		logic    insert;
		logic    remove;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    hold_first;
		logic    scan_start;
		logic    scan_issue;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  remove_bad;
		logic  swap_bad;
		logic  empty;
		logic  scan_last;
		logic  out_free;
	} dp_stat_t;

endpackage

/* hdl/rlsia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rlsia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/rlsia_ctrl.sv */
// Controller state machine for the record list block.
// Depends on rlsia_pkg; drives rlsia_dp through dp_cmd_t.
`timescale 1ns / 1ps

module rlsia_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rlsia_pkg::dp_stat_t stat,
	output rlsia_pkg::dp_cmd_t  cmd
);

	import rlsia_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.func)
					FUNC_SWAP: state_nxt = stat.swap_bad ? S_FINISH : S_SW_RD2;
					FUNC_FIND: state_nxt = stat.empty ? S_FINISH : S_FD_RUN;
					default:   state_nxt = S_FINISH;
				endcase
			end
			S_SW_RD2:  state_nxt = S_SW_WR1;
			S_SW_WR1:  state_nxt = S_SW_WR2;
			S_SW_WR2:  state_nxt = S_FINISH;
			S_FD_RUN: begin
				if (stat.scan_last) begin
					state_nxt = S_FD_TAIL;
				end
			end
			S_FD_TAIL: state_nxt = S_FINISH;
			S_FINISH: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		cmd.rd_sel = RD_FIRST;
		cmd.wr_sel = WR_INSERT;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load_in = req_valid;
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				unique case (stat.func)
					FUNC_INSERT: begin
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.insert = 1'b1;
							cmd.wr_en = 1'b1;
							cmd.wr_sel = WR_INSERT;
						end
					end
					FUNC_REMOVE: begin
						if (stat.remove_bad) begin
							cmd.status = ST_INVALID;
						end else begin
							cmd.remove = 1'b1;
						end
					end
					FUNC_SWAP: begin
						if (stat.swap_bad) begin
							cmd.status = ST_INVALID;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_FIRST;
						end
					end
					FUNC_FIND: begin
						if (stat.empty) begin
							cmd.status = ST_INVALID;
						end else begin
							cmd.scan_start = 1'b1;
						end
					end
					default: cmd.status = ST_INVALID;
				endcase
			end
			S_SW_RD2: begin
				// first entry is on the read port now, second read goes out
				cmd.hold_first = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_SECOND;
			end
			S_SW_WR1: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_FIRST;
			end
			S_SW_WR2: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_SECOND;
			end
			S_FD_RUN: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_SCAN;
				cmd.scan_issue = 1'b1;
			end
			S_FD_TAIL: begin
				cmd.set_status = 1'b1;
				cmd.status = ST_OK;
			end
			S_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/rlsia_dp.sv */
// Datapath of the record list block: entry RAM as a ring, length, scan, result register.
// Depends on rlsia_pkg and rlsia_ram; commanded by rlsia_ctrl.
`timescale 1ns / 1ps

module rlsia_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlsia_pkg::req_beat_t req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rlsia_pkg::rsp_beat_t rsp_data,
	input  rlsia_pkg::dp_cmd_t   cmd,
	output rlsia_pkg::dp_stat_t  stat
);

	import rlsia_pkg::*;

	localparam int SUM_W = IDX_W + 1;

	// logical position to physical RAM address, relative to the front slot
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= SUM_W'(LIST_DEPTH)) begin
			sum = sum - SUM_W'(LIST_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	req_beat_t        req_q;
	logic [IDX_W-1:0] head_q;
	logic [LEN_W-1:0] len_q;
	status_t          status_q;
	record_t          first_q;
	logic [IDX_W-1:0] scan_q;
	logic             scan_v_s1;
	logic [IDX_W-1:0] scan_idx_s1;
	record_t          best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	record_t          wr_rec;
	logic [REC_W-1:0] rd_raw;
	record_t          rd_rec;
	logic [CMP_W-1:0] len_c;
	logic             take_best;
	logic             found_ok;

	assign head_dec = (head_q == '0) ? IDX_W'(LIST_DEPTH - 1) : head_q - 1'b1;
	assign rd_rec = record_t'(rd_raw);

	always_comb begin
		case (cmd.rd_sel)
			RD_FIRST:  rd_addr = phys(head_q, IDX_W'(req_q.pos_first));
			RD_SECOND: rd_addr = phys(head_q, IDX_W'(req_q.pos_second));
			RD_SCAN:   rd_addr = phys(head_q, scan_q);
			default:   rd_addr = head_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_INSERT: begin
				wr_addr = head_dec;
				wr_rec.code = req_q.item_code;
				wr_rec.price = req_q.item_price;
				wr_rec.quantity = req_q.item_quantity;
			end
			WR_FIRST: begin
				wr_addr = phys(head_q, IDX_W'(req_q.pos_first));
				wr_rec = rd_rec;
			end
			WR_SECOND: begin
				wr_addr = phys(head_q, IDX_W'(req_q.pos_second));
				wr_rec = first_q;
			end
			default: begin
				wr_addr = head_q;
				wr_rec = rd_rec;
			end
		endcase
	end

	rlsia_ram #(
		.WIDTH(REC_W),
		.DEPTH(LIST_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_rec),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// status toward the controller
	assign len_c = CMP_W'(len_q);
	assign stat.func = req_q.func;
	assign stat.full = (len_q == LEN_W'(LIST_DEPTH));
	assign stat.remove_bad = (req_q.remove_count == '0) ||
		(CMP_W'(req_q.remove_count) > len_c);
	assign stat.swap_bad = (CMP_W'(req_q.pos_first) >= len_c) ||
		(CMP_W'(req_q.pos_second) >= len_c);
	assign stat.empty = (len_q == '0);
	assign stat.scan_last = ((LEN_W'(scan_q) + 1'b1) == len_q);
	assign stat.out_free = !rsp_valid_q || rsp_ready;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req_data;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.hold_first) begin
			first_q <= rd_rec;
		end
		if (cmd.scan_issue) begin
			scan_idx_s1 <= scan_q;
		end
		if (take_best) begin
			best_q <= rd_rec;
			best_idx_q <= scan_idx_s1;
		end
		if (cmd.out_load) begin
			rsp_q.status <= status_q;
			rsp_q.list_length <= 8'(len_q);
			rsp_q.found_index <= found_ok ? 7'(best_idx_q) : '0;
			rsp_q.found_code <= found_ok ? best_q.code : '0;
			rsp_q.found_price <= found_ok ? best_q.price : '0;
			rsp_q.found_quantity <= found_ok ? best_q.quantity : '0;
		end
	end

	// first scanned entry seeds the minimum; later ones replace it only when strictly lower
	assign take_best = scan_v_s1 &&
		((scan_idx_s1 == '0) || ($signed(rd_rec.price) < $signed(best_q.price)));
	assign found_ok = (req_q.func == FUNC_FIND) && (status_q == ST_OK);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			len_q <= '0;
			scan_q <= '0;
			scan_v_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				head_q <= head_dec;
				len_q <= len_q + 1'b1;
			end else if (cmd.remove) begin
				len_q <= len_q - LEN_W'(req_q.remove_count);
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_q <= scan_q + 1'b1;
			end
			scan_v_s1 <= cmd.scan_issue;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

/* hdl/record_list_shift_insert_argmin.sv */
// Record list with front insert, tail remove, swap and lowest-price search.
// A request passes the controller states IDLE, DECODE and FINISH; swap adds a second read and
// two writes, find lowest price one RAM read per stored entry and a tail state; one request at
// a time, the next is taken back in IDLE after the response is loaded, which waits for a free output.
// Front insert moves a ring head pointer, so no entry is copied.
// Reset (arst_n low, asynchronous) empties the list; entry RAM contents are not cleared.
`timescale 1ns / 1ps

module record_list_shift_insert_argmin (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rlsia_pkg::req_beat_t req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rlsia_pkg::rsp_beat_t rsp_data
);

	import rlsia_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rlsia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rlsia_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

/* hdl/rlsia_chk.sv */
// Port-level checker for the record list block, bound to the top level.
// Depends on rlsia_pkg and record_list_shift_insert_argmin_assert.svh.
`timescale 1ns / 1ps

`include "record_list_shift_insert_argmin_assert.svh"

module rlsia_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input rlsia_pkg::rsp_beat_t rsp_data
);

	import rlsia_pkg::*;

	// a stalled response beat holds
	`RLSIA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// one request in flight: ready drops right after a beat is taken
	`RLSIA_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

	// full is reported only at full length
	`RLSIA_ASSERT_IMP(a_full_len, rsp_valid && rsp_data.status == ST_FULL, rsp_data.list_length == 8'(LIST_DEPTH))

	// failed operations carry no found record
	`RLSIA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_data.status != ST_OK, rsp_data.found_index == '0 && rsp_data.found_code == '0 && rsp_data.found_price == '0 && rsp_data.found_quantity == '0)

	// a found position lies inside the list
	`RLSIA_ASSERT_IMP(a_idx_in_list, rsp_valid && rsp_data.found_index != '0, 8'(rsp_data.found_index) < rsp_data.list_length)

endmodule

bind record_list_shift_insert_argmin rlsia_chk u_rlsia_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data (rsp_data)
);
